// ----- design/mbx_pkg.sv -----
// Shared types and codes for the mailbox send/receive matcher.
package mbx_pkg;

	// Request operation codes.
	typedef enum logic [1:0] {
		OP_SEND  = 2'd0,
		OP_RECV  = 2'd1,
		OP_CHECK = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	// Ready mark values of a table entry.
	localparam logic MARK_PENDING = 1'b0;
	localparam logic MARK_READY   = 1'b1;

	// Command that the top level hands to one table and on down its row of cells.
	typedef struct packed {
		logic       claim_en;    // mark the oldest pending entry ready
		logic       append_en;   // write a new entry at the fill position
		logic       append_rdy;  // ready mark of the new entry
		logic [7:0] actor;
		logic [7:0] comm;
	} tbl_cmd_t;

	// Status that one table reports back to the top level.
	typedef struct packed {
		logic found;  // some valid entry is still pending
		logic hit;    // some valid entry matches the ids and is ready
		logic full;   // no free entry is left
	} tbl_stat_t;

endpackage

// ----- design/mbx_ifs.sv -----
// Valid/ready channel interfaces for the request and response beats.
interface mbx_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [7:0] owner;
	logic [7:0] comm_id;

	modport source (output valid, op, owner, comm_id, input ready);
	modport sink (input valid, op, owner, comm_id, output ready);
endinterface

interface mbx_rsp_if;
	logic valid;
	logic ready;
	logic ready_res;
	logic table_full;

	modport source (output valid, ready_res, table_full, input ready);
	modport sink (input valid, ready_res, table_full, output ready);
endinterface

// ----- design/mailbox_send_receive_matcher.sv -----
// Top level of the mailbox send/receive matcher: request stage, two tables, result register.
//
//   channel  modport  beat fields
//   req      sink     op, owner, comm_id
//   rsp      source   ready_res, table_full
//
// A request beat is registered on acceptance and executed once the result register is free,
// where both cell rows resolve the claim and hit chains and update at once.
// The request stage and then the response register lie between a request beat and its response
// beat; one request per cycle is sustained while the response side keeps taking beats.
// Reset clears only the fill counts and handshake state; entry storage is not reset.
// A response beat waiting on rsp.ready holds the execute stage, and with it req.ready.
module mailbox_send_receive_matcher #(
	parameter int SEND_DEPTH = 16,
	parameter int RECV_DEPTH = 16
) (
	input logic          clk,
	input logic          arst_n,
	mbx_req_if.sink      req,
	mbx_rsp_if.source    rsp
);

	logic                busy_q;
	mbx_pkg::op_t        op_s1;
	logic [7:0]          actor_s1;
	logic [7:0]          comm_s1;
	logic                exec;
	logic                out_valid_q;
	logic                ready_res_q;
	logic                table_full_q;
	mbx_pkg::tbl_cmd_t   send_cmd;
	mbx_pkg::tbl_cmd_t   recv_cmd;
	mbx_pkg::tbl_stat_t  send_stat;
	mbx_pkg::tbl_stat_t  recv_stat;
	logic                res_ready;
	logic                res_full;

	// Execute when a request is held and the result register is free.
	assign exec      = busy_q && (!out_valid_q || rsp.ready);
	assign req.ready = !busy_q || exec;

	// Request stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (req.valid && req.ready) begin
			busy_q <= 1'b1;
		end else if (exec) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_s1    <= mbx_pkg::op_t'(req.op);
			actor_s1 <= req.owner;
			comm_s1  <= req.comm_id;
		end
	end

	// Table commands: a post claims in the opposite table and appends to its own.
	always_comb begin
		send_cmd.actor      = actor_s1;
		send_cmd.comm       = comm_s1;
		send_cmd.claim_en   = exec && (op_s1 == mbx_pkg::OP_RECV) && !recv_stat.full;
		send_cmd.append_en  = exec && (op_s1 == mbx_pkg::OP_SEND) && !send_stat.full;
		send_cmd.append_rdy = recv_stat.found;
		recv_cmd.actor      = actor_s1;
		recv_cmd.comm       = comm_s1;
		recv_cmd.claim_en   = exec && (op_s1 == mbx_pkg::OP_SEND) && !send_stat.full;
		recv_cmd.append_en  = exec && (op_s1 == mbx_pkg::OP_RECV) && !recv_stat.full;
		recv_cmd.append_rdy = send_stat.found;
	end

	mbx_table #(.DEPTH(SEND_DEPTH)) u_send_tbl (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (send_cmd),
		.stat   (send_stat)
	);

	mbx_table #(.DEPTH(RECV_DEPTH)) u_recv_tbl (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (recv_cmd),
		.stat   (recv_stat)
	);

	// Result of the executing request.
	always_comb begin
		res_ready = 1'b0;
		res_full  = 1'b0;
		unique case (op_s1)
			mbx_pkg::OP_SEND: begin
				res_full  = send_stat.full;
				res_ready = !send_stat.full && recv_stat.found;
			end
			mbx_pkg::OP_RECV: begin
				res_full  = recv_stat.full;
				res_ready = !recv_stat.full && send_stat.found;
			end
			mbx_pkg::OP_CHECK: begin
				res_ready = send_stat.hit || recv_stat.hit;
			end
			mbx_pkg::OP_NONE: begin
				res_ready = 1'b0;
			end
			default: begin
				res_ready = 1'b0;
			end
		endcase
	end

	// Response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			ready_res_q  <= res_ready;
			table_full_q <= res_full;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.ready_res  = ready_res_q;
	assign rsp.table_full = table_full_q;

endmodule

// ----- design/mbx_cell.sv -----
// One table entry: ids and ready mark, with the claim and hit chains passing through.
module mbx_cell (
	input  logic              clk,
	input  mbx_pkg::tbl_cmd_t cmd,
	input  logic              valid,
	input  logic              sel,
	input  logic              claim_in,
	input  logic              hit_in,
	output logic              claim_out,
	output logic              hit_out
);

	logic [7:0] actor_q;
	logic [7:0] comm_q;
	logic       rdy_q;
	logic       pending;
	logic       take;

	// The claim token stops at the first valid pending entry.
	assign pending   = valid && (rdy_q == mbx_pkg::MARK_PENDING);
	assign take      = cmd.claim_en && claim_in && pending;
	assign claim_out = claim_in && !pending;

	// Hit chain ORs in a ready entry carrying the same ids.
	assign hit_out = hit_in || (valid && (rdy_q == mbx_pkg::MARK_READY)
		&& (actor_q == cmd.actor) && (comm_q == cmd.comm));

	// Entry storage: written on append, ready mark set when claimed.
	always_ff @(posedge clk) begin
		if (cmd.append_en && sel) begin
			actor_q <= cmd.actor;
			comm_q  <= cmd.comm;
			rdy_q   <= cmd.append_rdy;
		end else if (take) begin
			rdy_q <= mbx_pkg::MARK_READY;
		end
	end

endmodule

// ----- design/mbx_table.sv -----
// One posting table: a row of entry cells and its fill count.
module mbx_table #(
	parameter int DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  mbx_pkg::tbl_cmd_t  cmd,
	output mbx_pkg::tbl_stat_t stat
);

	localparam int CW = $clog2(DEPTH + 1);

	logic [CW-1:0]  count_q;
	logic [DEPTH:0] claim_c;
	logic [DEPTH:0] hit_c;
	logic [DEPTH-1:0] valid;
	logic [DEPTH-1:0] sel;

	assign claim_c[0] = 1'b1;
	assign hit_c[0]   = 1'b0;

	// Row of cells; entries below the count are valid, the fill position is selected.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		assign valid[i] = CW'(i) < count_q;
		assign sel[i]   = count_q == CW'(i);

		mbx_cell u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.valid     (valid[i]),
			.sel       (sel[i]),
			.claim_in  (claim_c[i]),
			.hit_in    (hit_c[i]),
			.claim_out (claim_c[i+1]),
			.hit_out   (hit_c[i+1])
		);
	end

	assign stat.found = !claim_c[DEPTH];
	assign stat.hit   = hit_c[DEPTH];
	assign stat.full  = count_q == CW'(DEPTH);

	// Fill count grows by one on each append.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.append_en) begin
			count_q <= count_q + CW'(1);
		end
	end

endmodule

// ----- bench/mailbox_send_receive_matcher_tb.sv -----
// Self-checking testbench for the mailbox send/receive matcher with a built-in table predictor.
module mailbox_send_receive_matcher_tb;

	localparam int TABLE_DEPTH = 16;
	localparam int SIDE_SEND   = 0;
	localparam int SIDE_RECV   = 1;
	localparam int RANDOM_REQS = 1300;
	localparam int IDLE_PCT    = 36;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		mbx_pkg::op_t op;
		logic [7:0]   actor;
		logic [7:0]   comm;
	} request_t;

	typedef struct packed {
		logic ready_res;
		logic table_full;
	} outcome_t;

	logic clk;
	logic arst_n;

	mbx_req_if req_ch ();
	mbx_rsp_if rsp_ch ();

	mailbox_send_receive_matcher #(
		.SEND_DEPTH(TABLE_DEPTH),
		.RECV_DEPTH(TABLE_DEPTH)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	// Shadow copy of both tables: index SIDE_SEND holds sends, SIDE_RECV holds receives.
	logic [15:0] entry_ids  [2][TABLE_DEPTH];
	logic        entry_mark [2][TABLE_DEPTH];
	int          entry_fill [2];

	request_t    queued_requests[$];
	outcome_t    expected_outcomes[$];
	logic [15:0] posted_ids[$];

	int total_requests;
	int req_beats;
	int rsp_beats;
	int error_count;
	int mismatch_count;
	int post_count;
	int check_count;
	int ready_count;
	int full_count;
	logic quiet;

	// Both sides stop idling for a stretch in the middle of the run.
	assign quiet = (req_beats >= 600) && (req_beats < 800);

	// Clock with a period of ten time units.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Applies one accepted request to the shadow tables and returns the response it must cause.
	function automatic outcome_t resolve_request(request_t r);
		outcome_t o;
		int own;
		int other;
		logic claimed;
		o = '0;
		claimed = 1'b0;
		case (r.op)
			mbx_pkg::OP_SEND, mbx_pkg::OP_RECV: begin
				own = (r.op == mbx_pkg::OP_SEND) ? SIDE_SEND : SIDE_RECV;
				other = (r.op == mbx_pkg::OP_SEND) ? SIDE_RECV : SIDE_SEND;
				if (entry_fill[own] >= TABLE_DEPTH) begin
					o.table_full = 1'b1;
				end else begin
					// The oldest pending entry of the opposite table is claimed.
					for (int i = 0; i < entry_fill[other]; i++) begin
						if (!claimed && entry_mark[other][i] == mbx_pkg::MARK_PENDING) begin
							entry_mark[other][i] = mbx_pkg::MARK_READY;
							claimed = 1'b1;
						end
					end
					entry_ids[own][entry_fill[own]] = {r.actor, r.comm};
					entry_mark[own][entry_fill[own]] =
						claimed ? mbx_pkg::MARK_READY : mbx_pkg::MARK_PENDING;
					entry_fill[own]++;
					o.ready_res = claimed;
				end
			end
			mbx_pkg::OP_CHECK: begin
				for (int s = 0; s < 2; s++) begin
					for (int i = 0; i < entry_fill[s]; i++) begin
						if (entry_ids[s][i] == {r.actor, r.comm} &&
								entry_mark[s][i] == mbx_pkg::MARK_READY)
							o.ready_res = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
		return o;
	endfunction

	// Ids come from a tiny pool often enough that different entries share them.
	function automatic logic [7:0] pick_id();
		if ($urandom_range(99) < 40)
			return 8'($urandom_range(3));
		return 8'($urandom_range(255));
	endfunction

	task automatic queue_request(mbx_pkg::op_t op, logic [7:0] actor, logic [7:0] comm);
		request_t r;
		r.op = op;
		r.actor = actor;
		r.comm = comm;
		queued_requests.push_back(r);
		if (op == mbx_pkg::OP_SEND || op == mbx_pkg::OP_RECV)
			posted_ids.push_back({actor, comm});
	endtask

	// Request driver: a new beat is offered once the previous one is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.op <= mbx_pkg::OP_NONE;
			req_ch.owner <= '0;
			req_ch.comm_id <= '0;
		end else if (!req_ch.valid || req_ch.ready) begin
			if (queued_requests.size() > 0 &&
					(quiet || $urandom_range(99) >= IDLE_PCT)) begin
				request_t r;
				r = queued_requests.pop_front();
				req_ch.valid <= 1'b1;
				req_ch.op <= r.op;
				req_ch.owner <= r.actor;
				req_ch.comm_id <= r.comm;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// Response sink stalls at random outside the quiet stretch.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// Monitor: predict on each request beat, compare each response beat with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				request_t r;
				outcome_t o;
				r.op = mbx_pkg::op_t'(req_ch.op);
				r.actor = req_ch.owner;
				r.comm = req_ch.comm_id;
				o = resolve_request(r);
				expected_outcomes.push_back(o);
				req_beats <= req_beats + 1;
				if (r.op == mbx_pkg::OP_SEND || r.op == mbx_pkg::OP_RECV)
					post_count++;
				if (r.op == mbx_pkg::OP_CHECK)
					check_count++;
				if (o.ready_res)
					ready_count++;
				if (o.table_full)
					full_count++;
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				rsp_beats <= rsp_beats + 1;
				if (expected_outcomes.size() == 0) begin
					error_count++;
					$display("unexpected response beat: ready_res=%0b table_full=%0b",
						rsp_ch.ready_res, rsp_ch.table_full);
				end else begin
					outcome_t want;
					want = expected_outcomes.pop_front();
					if (rsp_ch.ready_res !== want.ready_res ||
							rsp_ch.table_full !== want.table_full) begin
						error_count++;
						mismatch_count++;
						if (mismatch_count <= MAX_REPORTS)
							$display({"response %0d mismatch: ready_res exp %0b got %0b, ",
								"table_full exp %0b got %0b"},
								rsp_beats, want.ready_res, rsp_ch.ready_res,
								want.table_full, rsp_ch.table_full);
					end
				end
			end
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		logic [15:0] ids;
		int pick;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.op = mbx_pkg::OP_NONE;
		req_ch.owner = '0;
		req_ch.comm_id = '0;
		rsp_ch.ready = 1'b0;
		req_beats = 0;
		rsp_beats = 0;
		error_count = 0;
		mismatch_count = 0;
		post_count = 0;
		check_count = 0;
		ready_count = 0;
		full_count = 0;
		entry_fill[SIDE_SEND] = 0;
		entry_fill[SIDE_RECV] = 0;

		// Directed part: empty tables, unused op, id extremes, pending and claimed entries.
		queue_request(mbx_pkg::OP_CHECK, 8'h00, 8'h00);
		queue_request(mbx_pkg::OP_NONE, 8'hff, 8'hff);
		queue_request(mbx_pkg::OP_SEND, 8'h00, 8'h00);
		queue_request(mbx_pkg::OP_CHECK, 8'h00, 8'h00);
		queue_request(mbx_pkg::OP_RECV, 8'hff, 8'hff);
		queue_request(mbx_pkg::OP_CHECK, 8'h00, 8'h00);
		queue_request(mbx_pkg::OP_CHECK, 8'hff, 8'hff);
		queue_request(mbx_pkg::OP_CHECK, 8'h00, 8'hff);
		queue_request(mbx_pkg::OP_CHECK, 8'hff, 8'h00);
		queue_request(mbx_pkg::OP_RECV, 8'h55, 8'haa);
		queue_request(mbx_pkg::OP_RECV, 8'haa, 8'h55);
		queue_request(mbx_pkg::OP_CHECK, 8'h55, 8'haa);
		queue_request(mbx_pkg::OP_SEND, 8'h01, 8'h02);
		queue_request(mbx_pkg::OP_CHECK, 8'h55, 8'haa);
		queue_request(mbx_pkg::OP_CHECK, 8'haa, 8'h55);
		queue_request(mbx_pkg::OP_SEND, 8'h80, 8'h01);
		queue_request(mbx_pkg::OP_CHECK, 8'haa, 8'h55);
		queue_request(mbx_pkg::OP_CHECK, 8'h01, 8'h02);
		queue_request(mbx_pkg::OP_NONE, 8'h00, 8'h00);

		// Random part: posts fill both tables until they overflow, checks probe posted ids or random ids.
		for (int n = 0; n < RANDOM_REQS; n++) begin
			pick = $urandom_range(99);
			if (pick < 12) begin
				queue_request(mbx_pkg::OP_SEND, pick_id(), pick_id());
			end else if (pick < 24) begin
				queue_request(mbx_pkg::OP_RECV, pick_id(), pick_id());
			end else if (pick < 96) begin
				if (posted_ids.size() > 0 && $urandom_range(99) < 60) begin
					ids = posted_ids[$urandom_range(posted_ids.size() - 1)];
					if ($urandom_range(99) < 20)
						ids ^= 16'(1) << $urandom_range(15);
					queue_request(mbx_pkg::OP_CHECK, ids[15:8], ids[7:0]);
				end else begin
					queue_request(mbx_pkg::OP_CHECK, pick_id(), pick_id());
				end
			end else begin
				queue_request(mbx_pkg::OP_NONE, 8'($urandom_range(255)),
					8'($urandom_range(255)));
			end
		end
		total_requests = queued_requests.size();

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (req_beats < total_requests || expected_outcomes.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Run covered %0d request beats: %0d posts (%0d dropped on a full table), %0d checks.",
			req_beats, post_count, full_count, check_count);
		$display("Responses with ready set: %0d; mismatches: %0d.", ready_count, mismatch_count);
		if (error_count == 0) begin
			$display("mailbox_send_receive_matcher_tb: clean");
		end else begin
			$display("mailbox_send_receive_matcher_tb: errors");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#2000000;
		$display("mailbox_send_receive_matcher_tb: errors");
		$finish;
	end

endmodule
